>>> design/nsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_pkg: shared types and codes for the nearest seed lookup
// Sequencer states, configuration register indexes, request kinds and the
// control tag that travels with each operand set through the distance unit.
// ----------------------------------------------------------------------------
package nsv_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_SEED_COUNT   = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    // request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register reset values
    localparam logic [9:0]  SEED_COUNT_RST   = 10'd0;
    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    localparam int COLOR_BITS = 24;
    localparam int INDEX_BITS = 9;

    // query sequencer states
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BOUND  = 6'b000010,
        ST_RUN    = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_COLOR  = 6'b010000,
        ST_FINISH = 6'b100000
    } nsv_state_t;

    // control tag beside each operand set in the distance unit
    typedef struct packed {
        logic valid;
        logic bound;
    } nsv_tag_t;

endpackage

>>> design/nearest_seed_voronoi_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_seed_voronoi_lookup: brute force nearest seed search
// Holds a seed table with colors; a query walks the table through one shared
// squared distance unit and returns the closest seed and its color.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata seed/pixel, tuser kind
//  m_axis    out  m_axis_tvalid/tready      tdata index+color, tuser found
//  cfg       in   cfg_we                    cfg_addr, cfg_data
//
//  a load item writes the seed table and gives no result
//  a query walks n seeds, n the searched seed count: one seed a
//  cycle is read from the seed RAM port and fed to the distance pipeline,
//  then the pipeline drains and the winner's color is read back
//  s_axis_tready is low while a query is in progress
//  a result waits in the output register; loads are still taken meanwhile
// ----------------------------------------------------------------------------
module nearest_seed_voronoi_lookup #(
    parameter int MAX_SEEDS  = 512,
    parameter int COORD_BITS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    // [8:0] seed_index, [19:9] coord_x, [30:20] coord_y,
    // [38:31] red_in, [46:39] green_in, [54:47] blue_in
    input  logic [55:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] cell_index, [16:9] red_out, [24:17] green_out, [32:25] blue_out
    output logic [39:0] m_axis_tdata,
    // [0] found
    output logic        m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [11:0] cfg_data
);

    import nsv_pkg::*;

    localparam int AW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CW = $clog2(MAX_SEEDS + 1);
    localparam int OW = (COORD_BITS > 12) ? COORD_BITS : 12;
    localparam int DW = 2 * OW + 1;
    localparam int RW = 2 * COORD_BITS + COLOR_BITS;

    // configuration registers
    logic [9:0]  seed_count_reg;
    logic [11:0] frame_width_reg, frame_height_reg;

    // sequencer
    nsv_state_t          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       n_sat;
    logic [COORD_BITS-1:0] px_reg, py_reg;

    // fetch stage, aligned with the RAM read data
    nsv_tag_t            fetch_tag_reg, fetch_tag_next;
    logic [AW-1:0]       fetch_idx_reg;

    // running best
    logic [DW-1:0]       best_dist_reg, best_dist_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic                found_reg, found_next;

    // output register
    logic                out_valid_reg;
    logic [39:0]         out_data_reg;
    logic                out_found_reg;

    // memory and distance unit signals
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [RW-1:0]       ram_wdata, ram_rdata;
    logic [OW-1:0]       u_ax, u_bx, u_ay, u_by;
    nsv_tag_t            d_tag;
    logic [AW-1:0]       d_idx;
    logic [DW-1:0]       d_dist;
    logic                d_busy;
    logic                in_fire, out_slot;
    logic [COLOR_BITS-1:0] win_color;

    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_slot      = ~out_valid_reg | m_axis_tready;

    // seed count clipped to the table size
    assign n_sat = (32'(seed_count_reg) > MAX_SEEDS) ? CW'(MAX_SEEDS)
                                                      : CW'(seed_count_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_count_reg   <= SEED_COUNT_RST;
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SEED_COUNT:   seed_count_reg   <= cfg_data[9:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // seed table: loads write, the walk and the color fetch read
    // the winner's address is held while the result waits for the output slot
    assign ram_we    = in_fire && (s_axis_tuser == REQ_LOAD)
                       && (32'(s_axis_tdata[8:0]) < MAX_SEEDS);
    assign ram_waddr = AW'(s_axis_tdata[8:0]);
    assign ram_wdata = {s_axis_tdata[54:31], COORD_BITS'(s_axis_tdata[30:20]),
                        COORD_BITS'(s_axis_tdata[19:9])};
    assign ram_raddr = (state_reg inside {ST_COLOR, ST_FINISH}) ? best_idx_reg
                                                               : cnt_reg[AW-1:0];

    nsv_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SEEDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand select: the frame bound first, then pixel against each seed
    always_comb
    begin
        if (fetch_tag_reg.bound)
        begin
            u_ax = OW'(frame_width_reg);
            u_bx = '0;
            u_ay = OW'(frame_height_reg);
            u_by = '0;
        end
        else
        begin
            u_ax = OW'(px_reg);
            u_bx = OW'(ram_rdata[COORD_BITS-1:0]);
            u_ay = OW'(py_reg);
            u_by = OW'(ram_rdata[2*COORD_BITS-1:COORD_BITS]);
        end
    end

    nsv_dist #(
        .W  (OW),
        .IW (AW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (fetch_tag_reg),
        .in_idx   (fetch_idx_reg),
        .ax       (u_ax),
        .bx       (u_bx),
        .ay       (u_ay),
        .by       (u_by),
        .out_tag  (d_tag),
        .out_idx  (d_idx),
        .out_dist (d_dist),
        .busy     (d_busy)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        fetch_tag_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser == REQ_QUERY))
                begin
                    n_next     = n_sat;
                    cnt_next   = '0;
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                fetch_tag_next = '{valid: 1'b1, bound: 1'b1};
                state_next     = (n_reg == '0) ? ST_DRAIN : ST_RUN;
            end
            ST_RUN:
            begin
                fetch_tag_next = '{valid: 1'b1, bound: 1'b0};
                cnt_next       = cnt_reg + 1'b1;
                if ((cnt_reg + 1'b1) == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!fetch_tag_reg.valid && !d_busy)
                begin
                    state_next = ST_COLOR;
                end
            end
            ST_COLOR:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_slot)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // running minimum with strict less-than, so ties keep the lower index
    always_comb
    begin
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        if (d_tag.valid)
        begin
            if (d_tag.bound)
            begin
                best_dist_next = d_dist;
                best_idx_next  = '0;
                found_next     = 1'b0;
            end
            else if (d_dist < best_dist_reg)
            begin
                best_dist_next = d_dist;
                best_idx_next  = d_idx;
                found_next     = 1'b1;
            end
        end
    end

    assign win_color = ram_rdata[RW-1 -: COLOR_BITS];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            fetch_tag_reg <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            fetch_tag_reg <= fetch_tag_next;
            found_reg     <= found_next;
            if (state_reg == ST_FINISH && out_slot)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fetch_idx_reg <= cnt_reg[AW-1:0];
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (in_fire && (s_axis_tuser == REQ_QUERY))
        begin
            px_reg <= COORD_BITS'(s_axis_tdata[19:9]);
            py_reg <= COORD_BITS'(s_axis_tdata[30:20]);
        end
        if (state_reg == ST_FINISH && out_slot)
        begin
            out_found_reg <= found_reg;
            if (found_reg)
            begin
                out_data_reg <= {7'b0, win_color, INDEX_BITS'(best_idx_reg)};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

    // a query start always goes through the bound step first
    a_query_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tuser == REQ_QUERY) |=> (state_reg == ST_BOUND))
        else $error("query did not start with the bound step");

    // the color fetch only happens once every distance is folded in
    a_color_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLOR) |-> (!fetch_tag_reg.valid && !d_busy))
        else $error("color fetch with distances still in flight");

    // the walk never runs past the searched count
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg < n_reg))
        else $error("seed walk past the seed count");

    // a result with nothing found carries all zero data
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("nonzero data on a not found result");

endmodule

>>> design/nsv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_ram: generic single write port, single read port memory
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module nsv_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/nsv_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsv_dist: pipelined squared distance unit
// Three stages: absolute differences, squares, sum. Takes one operand set
// per cycle; the tag and index ride along beside the data.
// ----------------------------------------------------------------------------
module nsv_dist #(
    parameter int W  = 12,
    parameter int IW = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nsv_pkg::nsv_tag_t in_tag,
    input  logic [IW-1:0]     in_idx,
    input  logic [W-1:0]      ax,
    input  logic [W-1:0]      bx,
    input  logic [W-1:0]      ay,
    input  logic [W-1:0]      by,
    output nsv_pkg::nsv_tag_t out_tag,
    output logic [IW-1:0]     out_idx,
    output logic [2*W:0]      out_dist,
    output logic              busy
);

    import nsv_pkg::*;

    nsv_tag_t        s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [IW-1:0]   s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [W-1:0]    dx_reg, dy_reg;
    logic [2*W-1:0]  sqx_reg, sqy_reg;
    logic [2*W:0]    sum_reg;
    logic [W-1:0]    dx_next, dy_next;

    // absolute differences
    assign dx_next = (ax > bx) ? (ax - bx) : (bx - ax);
    assign dy_next = (ay > by) ? (ay - by) : (by - ay);

    // stage valids and tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        s2_idx_reg <= s1_idx_reg;
        sqx_reg    <= dx_reg * dx_reg;
        sqy_reg    <= dy_reg * dy_reg;
        s3_idx_reg <= s2_idx_reg;
        sum_reg    <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    assign out_tag  = s3_tag_reg;
    assign out_idx  = s3_idx_reg;
    assign out_dist = sum_reg;
    assign busy     = s1_tag_reg.valid | s2_tag_reg.valid | s3_tag_reg.valid;

endmodule
